/* src/lru_key_value_cache_defines.svh */
// Assertion macros used by the cache module to check its own logic.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define LKVC_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define LKVC_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/lkvc_pkg.sv */
package lkvc_pkg;

  // Default configuration of the cache.
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 64;

  // Fixed field widths.
  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Value returned by a get that misses.
  localparam logic signed [VALUE_W-1:0] MISS_VALUE = '1;

endpackage

/* src/lkvc_in_if.sv */
// Request channel: one get or put per transfer.
interface lkvc_in_if
  import lkvc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic        [KEY_W-1:0]   key;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

/* src/lkvc_out_if.sv */
// Result channel: one transfer per get.
interface lkvc_out_if
  import lkvc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [VALUE_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

/* src/lru_key_value_cache.sv */
// Channel  | Direction | Payload                      | Transfer
// ---------+-----------+------------------------------+------------------------
// in_ch    | sink      | command, key, value          | valid && ready
// out_ch   | source    | hit, read_value              | valid && ready
// cfg_*    | write     | cfg_wdata (capacity)         | cfg_we at clock edge
//
// One request is taken per cycle while the request register can advance; a get
// waits there while a stalled result holds the result register. A get passes
// through the input register and then the result register, which surround the
// combinational tag compare and rank update over all entries.
// A put produces no result and never waits on the result channel.
// Reset (synchronous, rst_n low) clears all valid bits, ranks, occupancy and
// sets capacity to sixteen; no clearing pass is needed.
// A stalled result holds the request register only when it holds a get.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lkvc_in_if.sink          in_ch,
  lkvc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Configuration.
  logic [CAP_W-1:0] cap_r;

  // Request register.
  logic                      inq_vld_r;
  logic                      inq_cmd_r;
  logic [KEY_BITS-1:0]       inq_key_r;
  logic signed [VALUE_W-1:0] inq_val_r;
  logic                      inq_vld_nxt;

  // Entry state.
  logic [ENTRIES-1:0]        valid_r;
  logic [RANK_W-1:0]         rank_r  [ENTRIES];
  logic [KEY_BITS-1:0]       key_r   [ENTRIES];
  logic signed [VALUE_W-1:0] value_r [ENTRIES];
  logic [OCC_W-1:0]          occ_r;
  logic [RANK_W-1:0]         rank_nxt [ENTRIES];

  // Result register.
  logic                      res_vld_r;
  logic                      res_hit_r;
  logic signed [VALUE_W-1:0] res_val_r;
  logic                      res_vld_nxt;

  // Lookup and update logic.
  logic                      in_xfer;
  logic                      advance;
  logic                      is_put;
  logic [ENTRIES-1:0]        hit_vec;
  logic [ENTRIES-1:0]        victim_vec;
  logic [ENTRIES-1:0]        free_vec;
  logic [ENTRIES-1:0]        tgt_vec;
  logic                      hit_any;
  logic [RANK_W-1:0]         hit_rank;
  logic signed [VALUE_W-1:0] hit_val;
  logic                      free_found;
  logic [OCC_W-1:0]          occ_m1;
  logic [CMP_W-1:0]          occ_ext;
  logic [CMP_W-1:0]          cap_ext;
  logic                      full;
  logic [OCC_W-1:0]          old_rank;
  logic                      promote_all;
  logic                      update;
  logic                      insert_new;

  // Handshake control: a put always proceeds, a get needs room for its result.
  assign is_put      = (inq_cmd_r == CMD_PUT);
  assign advance     = inq_vld_r && (is_put || !res_vld_r || out_ch.ready);
  assign in_ch.ready = !inq_vld_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = res_vld_r;
  assign out_ch.hit        = res_hit_r;
  assign out_ch.read_value = res_val_r;

  // Parallel tag compare and the value and rank of the matching entry.
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == inq_key_r);
      hit_rank   = hit_rank | (hit_vec[i] ? rank_r[i] : '0);
      hit_val    = hit_val | (hit_vec[i] ? value_r[i] : '0);
    end
    hit_any = |hit_vec;
  end

  // The least recent entry holds rank occupancy - 1.
  assign occ_m1 = occ_r - OCC_W'(1);
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = valid_r[i] && (OCC_W'(rank_r[i]) == occ_m1);
    end
  end

  // First free slot, lowest index wins.
  always_comb begin
    free_vec   = '0;
    free_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!valid_r[i] && !free_found) begin
        free_vec[i] = 1'b1;
        free_found  = 1'b1;
      end
    end
  end

  // Full when occupancy reaches capacity; zero counts as one, and the slot
  // count caps a larger setting.
  assign occ_ext = CMP_W'(occ_r);
  assign cap_ext = (cap_r == '0) ? CMP_W'(1) : CMP_W'(cap_r);
  assign full    = (occ_ext >= cap_ext) || (occ_r == OCC_W'(ENTRIES));

  // Choose the slot to touch and the rank it leaves.
  always_comb begin
    promote_all = 1'b0;
    if (hit_any) begin
      tgt_vec  = hit_vec;
      old_rank = OCC_W'(hit_rank);
    end else if (full) begin
      tgt_vec  = victim_vec;
      old_rank = occ_m1;
    end else begin
      tgt_vec     = free_vec;
      old_rank    = occ_r;
      promote_all = 1'b1;
    end
  end

  assign update     = advance && (is_put || hit_any);
  assign insert_new = advance && is_put && !hit_any && !full;

  // Promotion: the touched slot becomes rank zero, more recent entries age.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt_vec[i]) begin
        rank_nxt[i] = '0;
      end else if (valid_r[i] && (promote_all || (OCC_W'(rank_r[i]) < old_rank))) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  // Next state of the request and result valid flags.
  always_comb begin
    if (in_xfer) begin
      inq_vld_nxt = 1'b1;
    end else if (advance) begin
      inq_vld_nxt = 1'b0;
    end else begin
      inq_vld_nxt = inq_vld_r;
    end

    if (advance && !is_put) begin
      res_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      res_vld_nxt = 1'b0;
    end else begin
      res_vld_nxt = res_vld_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      inq_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      valid_r   <= '0;
      occ_r     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      inq_vld_r <= inq_vld_nxt;
      res_vld_r <= res_vld_nxt;
      if (update) begin
        for (int i = 0; i < ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
      if (insert_new) begin
        valid_r <= valid_r | tgt_vec;
        occ_r   <= occ_r + OCC_W'(1);
      end
    end
  end

  // Payload registers: request, stored entries and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      inq_cmd_r <= in_ch.command;
      inq_key_r <= in_ch.key[KEY_BITS-1:0];
      inq_val_r <= in_ch.value;
    end
    if (advance && is_put) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt_vec[i]) begin
          key_r[i]   <= inq_key_r;
          value_r[i] <= inq_val_r;
        end
      end
    end
    if (advance && !is_put) begin
      res_hit_r <= hit_any;
      res_val_r <= hit_any ? hit_val : MISS_VALUE;
    end
  end

  // Occupancy tracks the number of valid entries.
  `LKVC_ASSERT_ALWAYS(a_occ_count, clk, rst_n, $countones(valid_r) == int'(occ_r),
                      "occupancy differs from valid count")

  // Stored keys are distinct, so at most one entry matches.
  `LKVC_ASSERT_IMPLIES(a_hit_onehot, clk, rst_n, inq_vld_r, $onehot0(hit_vec),
                       "several entries match one key")

  // A miss result always carries the miss value.
  `LKVC_ASSERT_IMPLIES(a_miss_value, clk, rst_n, res_vld_r && !res_hit_r,
                       res_val_r == MISS_VALUE, "miss result without miss value")

  // An insert into a free slot always finds one.
  `LKVC_ASSERT_IMPLIES(a_free_slot, clk, rst_n, insert_new, free_found,
                       "insert without a free slot")

endmodule

/* tb/sv/lru_key_value_cache_test.sv */
`timescale 1ns / 100ps

module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam int SLOTS          = ENTRIES_DEF;
  // A get passes the request and result registers; a put leaves no trace on the result side.
  localparam int PIPE_DRAIN     = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 64;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic                      hit;
    logic signed [VALUE_W-1:0] read_value;
  } read_result_t;

  // Shadow copy of the cache with the queue of reads still owed by the block.
  class lru_mirror;
    bit                 valid_q[SLOTS];
    logic [KEY_W-1:0]   key_q[SLOTS];
    logic [VALUE_W-1:0] value_q[SLOTS];
    int unsigned        rank_q[SLOTS];
    int unsigned        occupancy;
    logic [CAP_W-1:0]   capacity;
    read_result_t       pending_reads[$];
    int                 errors;
    int                 reported;
    int                 requests;
    int                 reads_checked;
    int                 hits_checked;
    int                 evictions;

    function new();
      capacity = CAP_RESET;
      occupancy = 0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_q[i] = 1'b0;
        rank_q[i] = 0;
      end
    endfunction

    // Capacity zero acts as one, and anything above the slot count saturates.
    function int unsigned limit();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
    endfunction

    function int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_q[i] && key_q[i] == k) return i;
      end
      return -1;
    endfunction

    // Entries more recent than the promoted one move down by one rank.
    function void promote(int slot, int unsigned old_rank);
      for (int i = 0; i < SLOTS; i++) begin
        if (i != slot && valid_q[i] && rank_q[i] < old_rank) rank_q[i]++;
      end
      rank_q[slot] = 0;
    endfunction

    // Apply one accepted request; a get leaves the read it must return.
    function void accept_request(logic cmd, logic [KEY_W-1:0] k,
                                 logic signed [VALUE_W-1:0] v);
      int slot;
      int victim;
      read_result_t r;
      requests++;
      slot = find_slot(k);
      if (cmd == CMD_GET) begin
        if (slot >= 0) begin
          promote(slot, rank_q[slot]);
          r.hit = 1'b1;
          r.read_value = value_q[slot];
        end else begin
          r.hit = 1'b0;
          r.read_value = MISS_VALUE;
        end
        pending_reads.insert(pending_reads.size(), r);
        return;
      end
      if (slot >= 0) begin
        value_q[slot] = v;
        promote(slot, rank_q[slot]);
      end else if (occupancy >= limit()) begin
        // Full, or capacity lowered under the occupancy: reuse the oldest slot.
        victim = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_q[i] && (victim < 0 || rank_q[i] > rank_q[victim])) victim = i;
        end
        key_q[victim] = k;
        value_q[victim] = v;
        promote(victim, rank_q[victim]);
        evictions++;
      end else begin
        slot = 0;
        while (valid_q[slot]) slot++;
        valid_q[slot] = 1'b1;
        key_q[slot] = k;
        value_q[slot] = v;
        promote(slot, 32'hFFFF_FFFF);
        occupancy++;
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("ERROR at %0t: %s", $realtime, msg);
      end
    endfunction

    // Compare one read transfer with the oldest owed read.
    function void check_read(logic hit, logic signed [VALUE_W-1:0] rv);
      read_result_t exp;
      if (pending_reads.size() == 0) begin
        flag($sformatf("read with none owed: hit=%0b value=%0d", hit, rv));
        return;
      end
      exp = pending_reads.pop_front();
      reads_checked++;
      if (exp.hit) hits_checked++;
      if (hit !== exp.hit)
        flag($sformatf("read %0d hit: expected %0b, got %0b", reads_checked, exp.hit, hit));
      if (rv !== exp.read_value)
        flag($sformatf("read %0d value: expected %0d, got %0d",
                       reads_checked, exp.read_value, rv));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  bit               calm;
  int               holds_requested;
  int               holds_served;
  int               phases_run;

  lkvc_in_if  req_ch ();
  lkvc_out_if rsp_ch ();

  lru_mirror mirror = new();

  lru_key_value_cache i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure, plus a long hold when one is requested.
  always begin
    @(negedge clk);
    if (holds_requested != holds_served) begin
      holds_served++;
      repeat (HOLD_CYCLES) begin
        rsp_ch.ready <= 1'b0;
        @(negedge clk);
      end
    end
    rsp_ch.ready <= calm || ($urandom_range(99) >= 17);
  end

  // Sample both channels at the rising edge; results are checked first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) mirror.check_read(rsp_ch.hit, rsp_ch.read_value);
      if (req_ch.valid && req_ch.ready)
        mirror.accept_request(req_ch.command, req_ch.key, req_ch.value);
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles.", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one request, with random idle cycles ahead of it, until it transfers.
  task automatic send_request(logic cmd, logic [KEY_W-1:0] k, logic signed [VALUE_W-1:0] v);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 17) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.key     <= k;
    req_ch.value   <= v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Write the capacity only once every owed read is back and the pipe is empty.
  task automatic write_capacity(logic [CAP_W-1:0] c);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (mirror.pending_reads.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    mirror.capacity = c;
  endtask

  // Random traffic over a key pool a little larger than the capacity, so that
  // hits, updates and evictions all happen; a tenth of the keys are fresh.
  task automatic run_phase(logic [CAP_W-1:0] cap, int n, int get_pct, bit no_idle,
                           bit squeeze);
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] k;
    logic             cmd;
    int               pool_size;
    calm = no_idle;
    write_capacity(cap);
    pool_size = mirror.limit() + 1 + $urandom_range(3);
    repeat (pool_size) pool.insert(pool.size(), {$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 4) holds_requested++;
      if ($urandom_range(99) < 10) k = {$urandom, $urandom};
      else k = pool[$urandom_range(pool_size - 1)];
      cmd = ($urandom_range(99) < get_pct) ? CMD_GET : CMD_PUT;
      send_request(cmd, k, $urandom);
    end
    phases_run++;
  endtask

  initial begin
    logic [KEY_W-1:0] low_key;
    logic [KEY_W-1:0] high_key;
    low_key  = '0;
    high_key = '1;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_GET;
    req_ch.key     = '0;
    req_ch.value   = '0;
    calm           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty miss, key extremes, value extremes and an update.
    send_request(CMD_GET, low_key, $urandom);
    send_request(CMD_PUT, low_key, 32'sh7FFF_FFFF);
    send_request(CMD_PUT, high_key, 32'sh8000_0000);
    send_request(CMD_GET, high_key, $urandom);
    send_request(CMD_GET, low_key, $urandom);
    send_request(CMD_PUT, low_key, -32'sd1);
    send_request(CMD_GET, low_key, $urandom);

    // Fill all sixteen slots, then lower the capacity under the occupancy.
    for (int i = 0; i < SLOTS - 2; i++) send_request(CMD_PUT, 64'h4 << (4 * i), $urandom);
    write_capacity(5'd2);
    send_request(CMD_PUT, 64'hA5A5_5A5A_0F0F_F0F0, $urandom);
    send_request(CMD_GET, high_key, $urandom);
    send_request(CMD_GET, 64'hA5A5_5A5A_0F0F_F0F0, $urandom);
    send_request(CMD_PUT, 64'h0123_4567_89AB_CDEF, $urandom);
    send_request(CMD_GET, low_key, $urandom);

    // Random phases over several capacity settings, the extremes among them.
    run_phase(5'd1, 200, 50, 1'b0, 1'b0);
    run_phase(5'd0, 150, 50, 1'b0, 1'b0);
    run_phase(5'd31, 250, 50, 1'b1, 1'b0);
    run_phase(5'd3, 200, 60, 1'b0, 1'b0);
    run_phase(5'd16, 250, 80, 1'b0, 1'b1);
    run_phase(5'd17, 150, 50, 1'b0, 1'b0);
    run_phase(5'd8, 200, 50, 1'b0, 1'b0);
    run_phase(5'd2, 150, 50, 1'b0, 1'b0);
    run_phase(CAP_W'($urandom_range(31)), 200, 50, 1'b0, 1'b0);

    // Drain the owed reads, then give stray results time to show up.
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (mirror.pending_reads.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DRAIN) @(posedge clk);

    $display("Sent %0d requests, %0d random phases: %0d reads, %0d hits, %0d evictions.",
             mirror.requests, phases_run, mirror.reads_checked, mirror.hits_checked,
             mirror.evictions);
    $display("Capacities: zero, one, saturated and shrunk; %0d-cycle result stall; %0d errors.",
             HOLD_CYCLES, mirror.errors);
    if (mirror.errors == 0 && mirror.pending_reads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/lkvc_pkg.sv
src/lkvc_in_if.sv
src/lkvc_out_if.sv
src/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_test.sv
